[src/bcpnn_post_trace_update_assert.svh]
// Assertion macros shared by the post trace update block
`ifndef BCPNN_POST_TRACE_UPDATE_ASSERT_SVH
`define BCPNN_POST_TRACE_UPDATE_ASSERT_SVH

// Same-cycle implication
`define BPTU_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define BPTU_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Fixed-delay implication
`define BPTU_ASSERT_LAT(lbl, clk, rst_n, ante, dly, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> ##dly (cons)) \
        else $error(msg);

`endif

[src/bptu_pkg.sv]
// Types, constants and the log table function of the post trace update block
`timescale 1ns / 1ps

package bptu_pkg;

    localparam int UNIT_W             = 10;
    localparam int TRACE_W            = 16;
    localparam int BIAS_W             = 24;
    localparam int LN_W               = 24;
    localparam int CFG_IDX_W          = 3;
    localparam int CFG_DATA_W         = 16;
    localparam int UNITS_DEF          = 1024;
    localparam int LOG_TABLE_BITS_DEF = 8;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_P_RATE    = 3'd0,
        CFG_E_RATE    = 3'd1,
        CFG_ZJ_DECAY  = 3'd2,
        CFG_ZI_DECAY  = 3'd3,
        CFG_SPIKE_INC = 3'd4,
        CFG_BIAS_GAIN = 3'd5,
        CFG_LOG_FLOOR = 3'd6
    } t_cfg_idx;

    // Sequencer states
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_ADDR,
        S_READ,
        S_MUL,
        S_TAB,
        S_INT,
        S_GAIN,
        S_WB
    } t_state;

    typedef struct packed {
        logic [UNIT_W-1:0] unit;
        logic              spike;
    } t_in_item;

    typedef struct packed {
        logic [UNIT_W-1:0]        unit_out;
        logic signed [BIAS_W-1:0] bias;
        logic [TRACE_W-1:0]       p_trace;
        logic [TRACE_W-1:0]       z_trace;
        logic [TRACE_W-1:0]       epsc_out;
    } t_out_item;

    // One memory word holds all state of a unit
    typedef struct packed {
        logic signed [BIAS_W-1:0] bias;
        logic [TRACE_W-1:0]       p;
        logic [TRACE_W-1:0]       e;
        logic [TRACE_W-1:0]       z;
        logic [TRACE_W-1:0]       epsc;
    } t_word;

    // Stage enables from the sequencer to the datapath
    typedef struct packed {
        logic mul_en;
        logic tab_en;
        logic int_en;
        logic gain_en;
    } t_ctrl;

    // ln(1 + i/2^bits) with 24 fractional bits, from a 28 bit log2 by squaring
    function automatic logic [LN_W-1:0] ln_entry(input int unsigned i,
                                                 input int unsigned bits);
        logic [63:0] y;
        logic [63:0] lg;
        logic [63:0] t;
        int          k;
        y  = (64'd1 << 30) + ((64'(i) << 30) >> bits);
        lg = '0;
        if (y >= (64'd2 << 30)) begin
            lg = 64'd1 << 28;
            y  = y >> 1;
        end
        for (k = 27; k >= 0; k--) begin
            y = (y * y) >> 30;
            if (y >= (64'd2 << 30)) begin
                y     = y >> 1;
                lg[k] = 1'b1;
            end
        end
        t = (lg * 64'd2977044472 + (64'd1 << 35)) >> 36;
        return t[LN_W-1:0];
    endfunction

endpackage

[src/bptu_store.sv]
// Unit state memory: one word per unit, registered read port, one write port
`timescale 1ns / 1ps

module bptu_store
    import bptu_pkg::*;
#(
    parameter int UNITS = UNITS_DEF
) (
    input  logic                                      i_clk,
    input  logic                                      i_wr_en,
    input  logic [((UNITS > 1) ? $clog2(UNITS) : 1)-1:0] i_wr_addr,
    input  t_word                                     i_wr_data,
    input  logic                                      i_rd_en,
    input  logic [((UNITS > 1) ? $clog2(UNITS) : 1)-1:0] i_rd_addr,
    output t_word                                     o_rd_data
);

    t_word mem [UNITS];
    t_word r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, data registered from the address while the read enable is high
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[src/bptu_trace.sv]
// Trace filter datapath: decay, spike increment and the e and p followers
`timescale 1ns / 1ps

module bptu_trace
    import bptu_pkg::*;
(
    input  logic               i_clk,
    input  t_ctrl              i_ctrl,
    input  t_word              i_old,
    input  logic               i_spike,
    input  logic [TRACE_W-1:0] i_p_rate,
    input  logic [TRACE_W-1:0] i_e_rate,
    input  logic [TRACE_W-1:0] i_zj_decay,
    input  logic [TRACE_W-1:0] i_zi_decay,
    input  logic [TRACE_W-1:0] i_spike_inc,
    output logic [TRACE_W-1:0] o_p,
    output logic [TRACE_W-1:0] o_e,
    output logic [TRACE_W-1:0] o_z,
    output logic [TRACE_W-1:0] o_epsc
);

    // Round half away from zero of v / 2^16
    function automatic logic signed [17:0] rnd16(input logic signed [33:0] v);
        logic [33:0] mag;
        logic [33:0] q;
        mag = (v < 0) ? 34'(-v) : 34'(v);
        q   = (mag + 34'h8000) >> 16;
        return (v < 0) ? -$signed(q[17:0]) : $signed(q[17:0]);
    endfunction

    // Clip to 0..65535
    function automatic logic [TRACE_W-1:0] sat16(input logic signed [18:0] v);
        if (v < 0) begin
            return '0;
        end else if (v > 19'sd65535) begin
            return '1;
        end
        return v[TRACE_W-1:0];
    endfunction

    logic [16:0]        zi_keep;
    logic [16:0]        zj_keep;
    logic signed [16:0] d_ze;
    logic signed [16:0] d_ep;
    logic [32:0]        ep_full;
    logic [32:0]        z_full;
    logic signed [33:0] e_full;
    logic signed [33:0] p_full;

    logic [32:0]        r_ep_prod;
    logic [32:0]        r_z_prod;
    logic signed [33:0] r_e_prod;
    logic signed [33:0] r_p_prod;
    logic [TRACE_W-1:0] r_inc;

    logic [32:0]        ep_sum;
    logic [32:0]        z_sum;
    logic [17:0]        z_tot;
    logic signed [18:0] e_tot;
    logic signed [18:0] p_tot;

    logic [TRACE_W-1:0] r_p;
    logic [TRACE_W-1:0] r_e;
    logic [TRACE_W-1:0] r_z;
    logic [TRACE_W-1:0] r_epsc;

    // Products of the old state
    always_comb begin
        zi_keep = 17'h10000 - {1'b0, i_zi_decay};
        zj_keep = 17'h10000 - {1'b0, i_zj_decay};
        d_ze    = $signed({1'b0, i_old.z}) - $signed({1'b0, i_old.e});
        d_ep    = $signed({1'b0, i_old.e}) - $signed({1'b0, i_old.p});
        ep_full = i_old.epsc * zi_keep;
        z_full  = i_old.z * zj_keep;
        e_full  = d_ze * $signed({1'b0, i_e_rate});
        p_full  = d_ep * $signed({1'b0, i_p_rate});
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_en) begin
            r_ep_prod <= ep_full;
            r_z_prod  <= z_full;
            r_e_prod  <= e_full;
            r_p_prod  <= p_full;
            r_inc     <= i_spike ? i_spike_inc : '0;
        end
    end

    // Round, add and clip
    always_comb begin
        ep_sum = r_ep_prod + 33'h8000;
        z_sum  = r_z_prod + 33'h8000;
        z_tot  = {1'b0, z_sum[32:16]} + {2'b00, r_inc};
        e_tot  = $signed({3'b000, i_old.e}) + 19'(rnd16(r_e_prod));
        p_tot  = $signed({3'b000, i_old.p}) + 19'(rnd16(r_p_prod));
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.tab_en) begin
            r_epsc <= ep_sum[32] ? '1 : ep_sum[31:16];
            r_z    <= (z_tot[17:16] != 2'b00) ? '1 : z_tot[TRACE_W-1:0];
            r_e    <= sat16(e_tot);
            r_p    <= sat16(p_tot);
        end
    end

    assign o_p    = r_p;
    assign o_e    = r_e;
    assign o_z    = r_z;
    assign o_epsc = r_epsc;

endmodule

[src/bptu_bias.sv]
// Bias datapath: normalize p plus floor, table log with interpolation, gain
`timescale 1ns / 1ps

module bptu_bias
    import bptu_pkg::*;
#(
    parameter int LOG_TABLE_BITS = LOG_TABLE_BITS_DEF
) (
    input  logic                     i_clk,
    input  t_ctrl                    i_ctrl,
    input  logic [TRACE_W-1:0]       i_p_old,
    input  logic [TRACE_W-1:0]       i_log_floor,
    input  logic [TRACE_W-1:0]       i_bias_gain,
    output logic signed [BIAS_W-1:0] o_bias
);

    localparam int TAB_SIZE = (1 << LOG_TABLE_BITS) + 1;
    localparam int INTERP   = TRACE_W - LOG_TABLE_BITS;
    localparam logic [LN_W-1:0] LN2 = ln_entry(1 << LOG_TABLE_BITS, LOG_TABLE_BITS);
    localparam logic signed [LN_W:0] LN2_S = {1'b0, LN2};

    logic [LN_W-1:0] ln_tab [TAB_SIZE];

    // Constant table of ln(1 + i/2^B)
    for (genvar g = 0; g < TAB_SIZE; g++) begin : g_tab
        localparam logic [LN_W-1:0] ENTRY = ln_entry(g, LOG_TABLE_BITS);
        assign ln_tab[g] = ENTRY;
    end

    logic [16:0]               x;
    logic [4:0]                m;
    logic [16:0]               shifted;
    logic [LOG_TABLE_BITS-1:0] r_idx;
    logic [INTERP-1:0]         r_rem;
    logic [4:0]                r_m;
    logic                      r_zero;

    // Find the leading one of p + floor and take the mantissa
    always_comb begin
        x = {1'b0, i_p_old} + {1'b0, i_log_floor};
        m = '0;
        for (int k = 0; k < 17; k++) begin
            if (x[k]) begin
                m = 5'(k);
            end
        end
        shifted = x << (5'd16 - m);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_en) begin
            r_m    <= m;
            r_idx  <= shifted[TRACE_W-1 -: LOG_TABLE_BITS];
            r_rem  <= shifted[INTERP-1:0];
            r_zero <= (x == '0);
        end
    end

    logic signed [5:0]         m_s;
    logic signed [30:0]        mln_full;
    logic [LOG_TABLE_BITS:0]   idx_lo;
    logic [LOG_TABLE_BITS:0]   idx_hi;
    logic [LN_W-1:0]           r_lo;
    logic [LN_W-1:0]           r_hi;
    logic signed [29:0]        r_mln;

    // Look up both neighbors and the exponent term
    always_comb begin
        m_s      = $signed({1'b0, r_m}) - 6'sd16;
        mln_full = m_s * LN2_S;
        idx_lo   = {1'b0, r_idx};
        idx_hi   = idx_lo + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.tab_en) begin
            r_lo  <= ln_tab[idx_lo];
            r_hi  <= ln_tab[idx_hi];
            r_mln <= $signed(mln_full[29:0]);
        end
    end

    logic [LN_W-1:0]        diff;
    logic [LN_W+INTERP-1:0] dprod;
    logic signed [29:0]     lnv;
    logic signed [29:0]     r_lnv;

    // Interpolate between the two entries
    always_comb begin
        diff  = r_hi - r_lo;
        dprod = diff * r_rem;
        lnv   = r_mln + $signed({6'b0, r_lo}) + $signed({6'b0, dprod[LN_W+INTERP-1:INTERP]});
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.int_en) begin
            r_lnv <= lnv;
        end
    end

    logic signed [46:0] prod_full;
    logic signed [46:0] r_prod;

    // Apply the gain
    assign prod_full = $signed({1'b0, i_bias_gain}) * r_lnv;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.gain_en) begin
            r_prod <= prod_full;
        end
    end

    logic [46:0] mag;
    logic [46:0] q;

    // Round by 2^20 away from zero and clip to 24 bit signed; zero gain gives zero, zero x the minimum
    always_comb begin
        mag = (r_prod < 0) ? 47'(-r_prod) : 47'(r_prod);
        q   = (mag + 47'h80000) >> 20;
        if (i_bias_gain == '0) begin
            o_bias = '0;
        end else if (r_zero) begin
            o_bias = {1'b1, {(BIAS_W-1){1'b0}}};
        end else if (r_prod < 0) begin
            if (q > 47'd8388608) begin
                o_bias = {1'b1, {(BIAS_W-1){1'b0}}};
            end else begin
                o_bias = -$signed(q[BIAS_W-1:0]);
            end
        end else if (q > 47'd8388607) begin
            o_bias = {1'b0, {(BIAS_W-1){1'b1}}};
        end else begin
            o_bias = $signed(q[BIAS_W-1:0]);
        end
    end

endmodule

[src/bcpnn_post_trace_update.sv]
// Top level: sequencer, configuration registers and state memory of the update
//
// Usage:
//   Input channel: drive i_item (unit, spike) with start high while busy is
//   low; the item is taken at that clock edge. The unit index is reduced
//   modulo UNITS.
//   Result channel: o_valid is high for one cycle with o_result (unit_out,
//   bias, p_trace, z_trace, epsc_out). The receiver cannot stall it.
//   Configuration: i_cfg_valid with i_cfg_index and i_cfg_data writes one
//   register; o_cfg_ready is always high. Write only while busy is low and no
//   result is pending. Indexes beyond the register list are ignored.
// Timing:
//   The result appears in the cycle in which busy drops, so a new item is
//   taken only once the previous result is shown. The sequencer walks each
//   item through index reduction, the state memory read, the trace multiplies,
//   the log table, interpolation, the gain multiply and the write-back.
// Reset:
//   Control and configuration registers return to reset values, then a clearing
//   pass writes zero to all UNITS memory words, one per cycle, with busy high.
`timescale 1ns / 1ps
`include "bcpnn_post_trace_update_assert.svh"

module bcpnn_post_trace_update
    import bptu_pkg::*;
#(
    parameter int UNITS          = UNITS_DEF,
    parameter int LOG_TABLE_BITS = LOG_TABLE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  t_in_item              i_item,
    output logic                  o_valid,
    output t_out_item             o_result,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int ADDR_W    = (UNITS > 1) ? $clog2(UNITS) : 1;
    localparam int IN_SPAN   = 1 << UNIT_W;
    localparam int MOD_SHIFT = 24;
    localparam logic [MOD_SHIFT:0] RECIP =
        (MOD_SHIFT+1)'(((1 << MOD_SHIFT) + UNITS - 1) / UNITS);
    localparam logic [UNIT_W-1:0] UNITS_LO = UNIT_W'(UNITS % IN_SPAN);
    localparam logic [ADDR_W-1:0] LAST     = ADDR_W'(UNITS - 1);

    // Configuration registers
    logic [TRACE_W-1:0] r_p_rate;
    logic [TRACE_W-1:0] r_e_rate;
    logic [TRACE_W-1:0] r_zj_decay;
    logic [TRACE_W-1:0] r_zi_decay;
    logic [TRACE_W-1:0] r_spike_inc;
    logic [TRACE_W-1:0] r_bias_gain;
    logic [TRACE_W-1:0] r_log_floor;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_rate    <= '0;
            r_e_rate    <= '0;
            r_zj_decay  <= '0;
            r_zi_decay  <= '0;
            r_spike_inc <= '0;
            r_bias_gain <= 16'd256;
            r_log_floor <= 16'd1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_P_RATE:    r_p_rate    <= i_cfg_data;
                CFG_E_RATE:    r_e_rate    <= i_cfg_data;
                CFG_ZJ_DECAY:  r_zj_decay  <= i_cfg_data;
                CFG_ZI_DECAY:  r_zi_decay  <= i_cfg_data;
                CFG_SPIKE_INC: r_spike_inc <= i_cfg_data;
                CFG_BIAS_GAIN: r_bias_gain <= i_cfg_data;
                CFG_LOG_FLOOR: r_log_floor <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer
    t_state            r_state;
    t_state            n_state;
    logic [ADDR_W-1:0] r_clr;
    logic [ADDR_W-1:0] n_clr;
    t_ctrl             ctrl;
    logic              rd_en;
    logic              wr_en;
    logic              accept;

    assign accept = start && !busy;

    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        ctrl         = '0;
        rd_en        = 1'b0;
        wr_en        = 1'b0;
        busy         = 1'b1;
        case (r_state)
            S_CLEAR: begin
                wr_en = 1'b1;
                n_clr = r_clr + 1'b1;
                if (r_clr == LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    n_state = S_DIV;
                end
            end
            S_DIV:  n_state = S_ADDR;
            S_ADDR: n_state = S_READ;
            S_READ: begin
                rd_en   = 1'b1;
                n_state = S_MUL;
            end
            S_MUL: begin
                ctrl.mul_en = 1'b1;
                n_state     = S_TAB;
            end
            S_TAB: begin
                ctrl.tab_en = 1'b1;
                n_state     = S_INT;
            end
            S_INT: begin
                ctrl.int_en = 1'b1;
                n_state     = S_GAIN;
            end
            S_GAIN: begin
                ctrl.gain_en = 1'b1;
                n_state      = S_WB;
            end
            S_WB: begin
                wr_en   = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
        end
    end

    // Hold the item and reduce the unit index
    logic [UNIT_W-1:0]           r_raw;
    logic                        r_spike;
    logic [UNIT_W-1:0]           r_q;
    logic [UNIT_W-1:0]           r_mod;
    logic [UNIT_W+MOD_SHIFT:0]   q_full;
    logic [2*UNIT_W-1:0]         qu_full;

    assign q_full  = r_raw * RECIP;
    assign qu_full = r_q * UNITS_LO;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_raw   <= i_item.unit;
            r_spike <= i_item.spike;
        end
        if (r_state == S_DIV) begin
            r_q <= q_full[MOD_SHIFT +: UNIT_W];
        end
        if (r_state == S_ADDR) begin
            if (UNITS >= IN_SPAN) begin
                r_mod <= r_raw;
            end else begin
                r_mod <= r_raw - qu_full[UNIT_W-1:0];
            end
        end
    end

    // State memory
    t_word             rd_data;
    t_word             wr_data;
    logic [ADDR_W-1:0] unit_addr;
    logic [ADDR_W-1:0] wr_addr;

    assign unit_addr = ADDR_W'(r_mod);
    assign wr_addr   = (r_state == S_CLEAR) ? r_clr : unit_addr;

    bptu_store #(
        .UNITS (UNITS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (unit_addr),
        .o_rd_data (rd_data)
    );

    // Trace and bias datapaths
    logic [TRACE_W-1:0]       new_p;
    logic [TRACE_W-1:0]       new_e;
    logic [TRACE_W-1:0]       new_z;
    logic [TRACE_W-1:0]       new_epsc;
    logic signed [BIAS_W-1:0] new_bias;
    logic signed [BIAS_W-1:0] bias_sel;

    bptu_trace u_trace (
        .i_clk       (i_clk),
        .i_ctrl      (ctrl),
        .i_old       (rd_data),
        .i_spike     (r_spike),
        .i_p_rate    (r_p_rate),
        .i_e_rate    (r_e_rate),
        .i_zj_decay  (r_zj_decay),
        .i_zi_decay  (r_zi_decay),
        .i_spike_inc (r_spike_inc),
        .o_p         (new_p),
        .o_e         (new_e),
        .o_z         (new_z),
        .o_epsc      (new_epsc)
    );

    bptu_bias #(
        .LOG_TABLE_BITS (LOG_TABLE_BITS)
    ) u_bias (
        .i_clk       (i_clk),
        .i_ctrl      (ctrl),
        .i_p_old     (rd_data.p),
        .i_log_floor (r_log_floor),
        .i_bias_gain (r_bias_gain),
        .o_bias      (new_bias)
    );

    // Keep the stored bias when the p rate is zero
    assign bias_sel = (r_p_rate != '0) ? new_bias : rd_data.bias;

    always_comb begin
        if (r_state == S_CLEAR) begin
            wr_data = '0;
        end else begin
            wr_data.bias = bias_sel;
            wr_data.p    = new_p;
            wr_data.e    = new_e;
            wr_data.z    = new_z;
            wr_data.epsc = new_epsc;
        end
    end

    // Result register, one-cycle strobe
    logic      r_valid;
    t_out_item r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= (r_state == S_WB);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_WB) begin
            r_res.unit_out <= r_mod;
            r_res.bias     <= bias_sel;
            r_res.p_trace  <= new_p;
            r_res.z_trace  <= new_z;
            r_res.epsc_out <= new_epsc;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_res;

    // Checks
    `BPTU_ASSERT_LAT(a_latency, i_clk, i_rst_n, start && !busy, 9, o_valid, "result latency is not 9 cycles")
    `BPTU_ASSERT_NXT(a_strobe, i_clk, i_rst_n, o_valid, !o_valid, "result strobe longer than one cycle")
    `BPTU_ASSERT_IMP(a_idle_out, i_clk, i_rst_n, o_valid, !busy, "result shown while busy")
    `BPTU_ASSERT_NXT(a_take, i_clk, i_rst_n, start && !busy, busy, "accepted item did not raise busy")

endmodule

[test/tb_bcpnn_post_trace_update.sv]
// Self-checking testbench of the post trace update block against a built-in trace and bias model
`timescale 1ns / 1ps

module tb_bcpnn_post_trace_update;
    import bptu_pkg::*;

    localparam int UNITS         = UNITS_DEF;
    localparam int TABLE_BITS    = LOG_TABLE_BITS_DEF;
    localparam int TABLE_SIZE    = (1 << TABLE_BITS) + 1;
    localparam int INTERP_BITS   = 16 - TABLE_BITS;
    localparam longint BIAS_MIN  = -8388608;
    localparam longint BIAS_MAX  = 8388607;
    localparam int MAX_REPORTS   = 10;
    localparam int END_PAD       = 20;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 200;
    localparam int POOL_SIZE     = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;

    typedef struct {
        t_in_item item;
        bit       drain;
    } t_queued_update;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  start       = 1'b0;
    logic                  busy;
    t_in_item              i_item      = '0;
    logic                  o_valid;
    t_out_item             o_result;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    // Register copies used for prediction
    logic [15:0] rate_p    = 16'd0;
    logic [15:0] rate_e    = 16'd0;
    logic [15:0] decay_zj  = 16'd0;
    logic [15:0] decay_zi  = 16'd0;
    logic [15:0] spike_inc = 16'd0;
    logic [15:0] gain_bias = 16'd256;
    logic [15:0] floor_log = 16'd1;

    // Per-unit trace state of the model
    logic [15:0]        p_mem    [UNITS];
    logic [15:0]        e_mem    [UNITS];
    logic [15:0]        z_mem    [UNITS];
    logic [15:0]        epsc_mem [UNITS];
    logic signed [23:0] bias_mem [UNITS];
    longint             ln_table [TABLE_SIZE];

    t_queued_update update_queue[$];
    t_out_item      expected_results[$];

    int unsigned items_queued = 0;
    int unsigned items_taken  = 0;
    int unsigned results_seen = 0;
    int unsigned error_count  = 0;
    int          gap_pct      = 0;

    bcpnn_post_trace_update #(
        .UNITS          (UNITS),
        .LOG_TABLE_BITS (TABLE_BITS)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_valid     (o_valid),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // Round half away from zero, then drop s fraction bits
    function automatic longint round_shift(input longint v, input int s);
        longint half;
        half = longint'(1) << (s - 1);
        if (v >= 0) return (v + half) >>> s;
        return -((-v + half) >>> s);
    endfunction

    function automatic logic [15:0] clamp_trace(input longint v);
        if (v < 0) return 16'd0;
        if (v > 65535) return 16'hFFFF;
        return v[15:0];
    endfunction

    // Advance one unit's traces and bias, return the result the block must give
    function automatic t_out_item predict_update(input t_in_item it);
        t_out_item r;
        int        u;
        longint    p, e, z, ep, x, lnv, prod, b;
        int        m, frac, idx, rem;
        logic [15:0] np, ne, nz, nep;
        u  = int'(it.unit) % UNITS;
        p  = longint'(p_mem[u]);
        e  = longint'(e_mem[u]);
        z  = longint'(z_mem[u]);
        ep = longint'(epsc_mem[u]);

        nep = clamp_trace(round_shift(ep * (65536 - longint'(decay_zi)), 16));

        // Bias from ln(p + floor) of the old p, only while the p rate is on
        if (rate_p != 16'd0) begin
            x = p + longint'(floor_log);
            if (gain_bias == 16'd0) begin
                bias_mem[u] = '0;
            end else if (x == 0) begin
                bias_mem[u] = BIAS_MIN[23:0];
            end else begin
                m = 0;
                while (m < 16 && (x >> (m + 1)) != 0) m++;
                frac = int'(((x << (16 - m)) & 64'h1FFFF) - 65536);
                idx  = frac >> INTERP_BITS;
                rem  = frac & ((1 << INTERP_BITS) - 1);
                lnv  = (longint'(m) - 16) * ln_table[TABLE_SIZE-1] + ln_table[idx]
                     + (((ln_table[idx+1] - ln_table[idx]) * longint'(rem)) >>> INTERP_BITS);
                prod = longint'(gain_bias) * lnv;
                b    = round_shift(prod, 20);
                if (b < BIAS_MIN) b = BIAS_MIN;
                if (b > BIAS_MAX) b = BIAS_MAX;
                bias_mem[u] = b[23:0];
            end
        end

        np = clamp_trace(p + round_shift((e - p) * longint'(rate_p), 16));
        ne = clamp_trace(e + round_shift((z - e) * longint'(rate_e), 16));
        nz = clamp_trace(round_shift(z * (65536 - longint'(decay_zj)), 16)
                         + (it.spike ? longint'(spike_inc) : 64'sd0));

        p_mem[u]    = np;
        e_mem[u]    = ne;
        z_mem[u]    = nz;
        epsc_mem[u] = nep;

        r.unit_out = u[UNIT_W-1:0];
        r.bias     = bias_mem[u];
        r.p_trace  = np;
        r.z_trace  = nz;
        r.epsc_out = nep;
        return r;
    endfunction

    // Build the ln table by repeated squaring and clear the model state
    initial begin : init_model
        longint unsigned y, lg;
        int              i, k;
        for (i = 0; i < TABLE_SIZE; i++) begin
            y  = (64'd1 << 30) + ((longint'(i) << 30) >> TABLE_BITS);
            lg = 0;
            if (y >= (64'd2 << 30)) begin
                lg = 64'd1 << 28;
                y  = y >> 1;
            end
            for (k = 27; k >= 0; k--) begin
                y = (y * y) >> 30;
                if (y >= (64'd2 << 30)) begin
                    y  = y >> 1;
                    lg = lg | (64'd1 << k);
                end
            end
            ln_table[i] = longint'((lg * 64'd2977044472 + (64'd1 << 35)) >> 36);
        end
        for (i = 0; i < UNITS; i++) begin
            p_mem[i]    = '0;
            e_mem[i]    = '0;
            z_mem[i]    = '0;
            epsc_mem[i] = '0;
            bias_mem[i] = '0;
        end
    end

    // Present queued items, predict each one as it is taken
    always @(posedge i_clk) begin : drive_items
        int unsigned taken_now;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            taken_now = items_taken;
            if (start && !busy) begin
                expected_results = {expected_results, predict_update(i_item)};
                taken_now = items_taken + 1;
                items_taken <= taken_now;
            end
            if (!start || !busy) begin
                if (update_queue.size() != 0
                    && !(update_queue[0].drain && results_seen != taken_now)
                    && $urandom_range(0, 99) >= gap_pct) begin
                    start  <= 1'b1;
                    i_item <= update_queue[0].item;
                    void'(update_queue.pop_front());
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Check each result against the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_out_item want;
        if (i_rst_n && o_valid) begin
            results_seen <= results_seen + 1;
            if (expected_results.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("unexpected result: unit %0d bias %h p %h z %h epsc %h",
                             o_result.unit_out, o_result.bias, o_result.p_trace,
                             o_result.z_trace, o_result.epsc_out);
            end else begin
                want = expected_results.pop_front();
                if (o_result.unit_out !== want.unit_out || o_result.bias !== want.bias
                    || o_result.p_trace !== want.p_trace
                    || o_result.z_trace !== want.z_trace
                    || o_result.epsc_out !== want.epsc_out) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS) begin
                        $display("mismatch: expected unit %0d bias %h p %h z %h epsc %h",
                                 want.unit_out, want.bias, want.p_trace, want.z_trace,
                                 want.epsc_out);
                        $display("          got      unit %0d bias %h p %h z %h epsc %h",
                                 o_result.unit_out, o_result.bias, o_result.p_trace,
                                 o_result.z_trace, o_result.epsc_out);
                    end
                end
            end
        end
    end

    // Write one register; call aligned to a rising edge
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_P_RATE:    rate_p    = val;
            CFG_E_RATE:    rate_e    = val;
            CFG_ZJ_DECAY:  decay_zj  = val;
            CFG_ZI_DECAY:  decay_zi  = val;
            CFG_SPIKE_INC: spike_inc = val;
            CFG_BIAS_GAIN: gain_bias = val;
            CFG_LOG_FLOOR: floor_log = val;
            default: ;
        endcase
    endtask

    // Write the whole register set, the unused index first
    task automatic load_settings(input logic [15:0] pr, input logic [15:0] er,
                                 input logic [15:0] zj, input logic [15:0] zi,
                                 input logic [15:0] si, input logic [15:0] bg,
                                 input logic [15:0] lf);
        write_reg(CFG_IDX_SPARE, 16'($urandom));
        write_reg(CFG_P_RATE, pr);
        write_reg(CFG_E_RATE, er);
        write_reg(CFG_ZJ_DECAY, zj);
        write_reg(CFG_ZI_DECAY, zi);
        write_reg(CFG_SPIKE_INC, si);
        write_reg(CFG_BIAS_GAIN, bg);
        write_reg(CFG_LOG_FLOOR, lf);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic queue_item(input int unit, input bit spike, input bit drain);
        t_queued_update q;
        q.item.unit  = unit[UNIT_W-1:0];
        q.item.spike = spike;
        q.drain      = drain;
        update_queue = {update_queue, q};
        items_queued++;
    endtask

    // Hold until every queued item is taken and every result is back
    task automatic wait_idle();
        do @(posedge i_clk);
        while (items_taken != items_queued || results_seen != items_taken || busy);
    endtask

    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(0, 255));
            3:       return 16'($urandom_range(0, 4095));
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin : run_test
        int unit_pool [POOL_SIZE];
        int ph, n, j;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);
        // Hold off until the clearing pass ends
        do @(posedge i_clk); while (busy);

        gap_pct = 33;

        // Bias off, z saturates on repeated spikes, e follows z at full rate
        load_settings(16'd0, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 16'd256, 16'd1);
        queue_item(0, 1'b1, 1'b0);
        queue_item(1023, 1'b1, 1'b0);
        queue_item(0, 1'b1, 1'b0);
        queue_item(0, 1'b0, 1'b0);
        queue_item(1023, 1'b0, 1'b0);
        wait_idle();

        // Log of zero on a fresh unit, full rates and decays, largest gain
        load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0);
        queue_item(5, 1'b0, 1'b0);
        queue_item(0, 1'b0, 1'b0);
        queue_item(0, 1'b1, 1'b0);
        wait_idle();

        // Zero gain with the largest floor
        load_settings(16'hFFFF, 16'd4096, 16'd100, 16'd0, 16'd3000, 16'd0, 16'hFFFF);
        queue_item(0, 1'b0, 1'b0);
        queue_item(1023, 1'b1, 1'b0);
        wait_idle();

        // Negative bias overflow at x = 1, then a large x
        load_settings(16'hFFFF, 16'd30000, 16'd500, 16'd1000, 16'd20000, 16'hFFFF, 16'd1);
        queue_item(7, 1'b1, 1'b0);
        queue_item(0, 1'b1, 1'b0);
        queue_item(1023, 1'b0, 1'b0);
        wait_idle();

        // Bias off again: the stored bias must come back unchanged
        load_settings(16'd0, 16'd2000, 16'd2000, 16'd2000, 16'd2000, 16'd256, 16'd1);
        queue_item(0, 1'b0, 1'b0);
        queue_item(7, 1'b1, 1'b0);
        wait_idle();

        // Random phases: all-max, all-zero, then random settings
        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            gap_pct = (ph < 3) ? 33 : (ph < 6) ? 82 : 0;
            if (ph == 0)
                load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                              16'hFFFF);
            else if (ph == 1)
                load_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
            else
                load_settings(pick_value(), pick_value(), pick_value(), pick_value(),
                              pick_value(), pick_value(), pick_value());
            for (j = 0; j < POOL_SIZE; j++) unit_pool[j] = $urandom_range(0, UNITS - 1);
            // Mostly revisit a few units so their traces build up
            for (n = 0; n < PHASE_ITEMS; n++) begin
                queue_item(($urandom_range(0, 3) != 0)
                               ? unit_pool[$urandom_range(0, POOL_SIZE - 1)]
                               : int'($urandom_range(0, UNITS - 1)),
                           1'($urandom_range(0, 1)),
                           n == PHASE_ITEMS / 2 || $urandom_range(0, 39) == 0);
            end
            wait_idle();
        end

        repeat (END_PAD) @(posedge i_clk);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Stop a hung run
    initial begin : watchdog
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
